/* rtl/fws_pkg.sv */
// ----------------------------------------------------------------------------
// fws_pkg: shared definitions of the focal window statistics block
// Field widths, register indexes, command and operation codes, and the
// default store dimensions handed to the top level.
// ----------------------------------------------------------------------------
package fws_pkg;

  // Default store dimensions and window limit.
  localparam int MAX_COLS_DEF   = 64;
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_RADIUS_DEF = 7;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W   = 32;
  localparam int STAT_W     = 40;
  localparam int CNT_W      = 8;
  localparam int POS_W      = 6;
  localparam int DIM_W      = 7;
  localparam int RAD_W      = 3;
  localparam int COORD_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Statistic selected by the op_mode register.
  typedef enum logic [1:0] {
    OP_MAX  = 2'd0,
    OP_MIN  = 2'd1,
    OP_SUM  = 2'd2,
    OP_MEAN = 2'd3
  } op_t;

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_VALUE = 3'd5;

endpackage

/* rtl/focal_window_stats_unit.sv */
// ----------------------------------------------------------------------------
// focal_window_stats_unit: square-window statistic over a sample grid
// Stores signed samples in a grid and returns max, min, sum or mean of the
// valid cells in a window around a queried cell.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken when start is high and busy is low. A write item
// (cmd = 0) stores sample at (col, row) in that same cycle; busy stays low
// and no result follows, so a new item may follow in the next cycle.
// A query item (cmd = 1) raises busy until its result is shown. The window
// is walked one cell per cycle through the single read port of the grid
// memory, and one shared add/compare unit folds each cell into the
// accumulator. A query passes the setup, prep, walk, drain and final
// states, skipping the walk and drain for an empty window; a mean with at
// least one valid cell then runs the bit-serial divider. A window holds
// at most 15 x 15 cells.
// The result is on stat_value, valid_count and empty_res for exactly one
// cycle with done high; the receiver cannot hold it off. busy falls in the
// same cycle that done is shown.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata at any
// edge, and is meant to change only while busy is low.
// Reset restores the register defaults and idles the sequencer. The grid
// memory is not cleared: a cell reads as garbage until written.
// ----------------------------------------------------------------------------
module focal_window_stats_unit #(
  parameter int MAX_COLS   = fws_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = fws_pkg::MAX_ROWS_DEF,
  parameter int MAX_RADIUS = fws_pkg::MAX_RADIUS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Item channel
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    cmd,
  input  logic        [fws_pkg::POS_W-1:0]        col,
  input  logic        [fws_pkg::POS_W-1:0]        row,
  input  logic signed [fws_pkg::SAMPLE_W-1:0]     sample,
  // Result channel
  output logic                                    done,
  output logic signed [fws_pkg::STAT_W-1:0]       stat_value,
  output logic        [fws_pkg::CNT_W-1:0]        valid_count,
  output logic                                    empty_res,
  // Configuration port
  input  logic                                    cfg_we,
  input  logic        [fws_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic        [fws_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW     = fws_pkg::STAT_W;
  localparam int DW     = fws_pkg::SAMPLE_W;
  localparam int CRD_W  = fws_pkg::COORD_W;
  localparam int XY_W   = fws_pkg::DIM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_PREP,
    S_WALK,
    S_DRAIN,
    S_POST,
    S_DIV
  } state_t;

  state_t state;

  // Configuration registers.
  logic        [fws_pkg::DIM_W-1:0] grid_width;
  logic        [fws_pkg::DIM_W-1:0] grid_height;
  logic        [fws_pkg::RAD_W-1:0] radius;
  fws_pkg::op_t                     op_mode;
  logic                             skip_enable;
  logic signed [DW-1:0]             missing_value;

  // Query and walk registers.
  logic [fws_pkg::POS_W-1:0] col_q;
  logic [fws_pkg::POS_W-1:0] row_q;
  logic [XY_W-1:0]           x0, x1, y0, y1;
  logic [XY_W-1:0]           x, y;
  logic                      win_empty;
  logic [ADDR_W-1:0]         rowbase;
  logic                      rd_pend;

  // Accumulator.
  logic signed [SW-1:0]         acc;
  logic                         acc_valid;
  logic [fws_pkg::CNT_W-1:0]    count;

  // Memory and divider connections.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DW-1:0]     mem_rdata;
  logic              div_start;
  logic              div_done;
  logic signed [SW-1:0] div_quo;

  logic item_take;

  assign busy      = (state != S_IDLE);
  assign item_take = start && !busy;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width    <= fws_pkg::DIM_W'(1);
      grid_height   <= fws_pkg::DIM_W'(1);
      radius        <= '0;
      op_mode       <= fws_pkg::OP_MAX;
      skip_enable   <= 1'b0;
      missing_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fws_pkg::REG_GRID_WIDTH:    grid_width    <= cfg_wdata[fws_pkg::DIM_W-1:0];
        fws_pkg::REG_GRID_HEIGHT:   grid_height   <= cfg_wdata[fws_pkg::DIM_W-1:0];
        fws_pkg::REG_RADIUS:        radius        <= cfg_wdata[fws_pkg::RAD_W-1:0];
        fws_pkg::REG_OP_MODE:       op_mode       <= fws_pkg::op_t'(cfg_wdata[1:0]);
        fws_pkg::REG_SKIP_ENABLE:   skip_enable   <= cfg_wdata[0];
        fws_pkg::REG_MISSING_VALUE: missing_value <= $signed(cfg_wdata[DW-1:0]);
        default: ;
      endcase
    end
  end

  // Sample writes go straight into the grid memory when inside the store.
  always_comb begin
    mem_we    = item_take && (cmd == fws_pkg::CMD_WRITE)
                && (int'(col) < MAX_COLS) && (int'(row) < MAX_ROWS);
    mem_waddr = ADDR_W'(int'(row) * MAX_COLS + int'(col));
    mem_raddr = rowbase + ADDR_W'(x);
  end

  fws_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (sample),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Window bounds: clip the square around the centre to the effective grid.
  logic [XY_W-1:0]         w_eff, h_eff, rad_eff;
  logic signed [CRD_W-1:0] c_s, r_s, rad_s, w_s, h_s;
  logic signed [CRD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [CRD_W-1:0] x0_s, x1_s, y0_s, y1_s;

  always_comb begin
    w_eff   = (int'(grid_width) < MAX_COLS) ? grid_width : XY_W'(MAX_COLS);
    h_eff   = (int'(grid_height) < MAX_ROWS) ? grid_height : XY_W'(MAX_ROWS);
    rad_eff = (int'(radius) < MAX_RADIUS) ? XY_W'(radius) : XY_W'(MAX_RADIUS);
    c_s   = $signed({3'b000, col_q});
    r_s   = $signed({3'b000, row_q});
    rad_s = $signed({2'b00, rad_eff});
    w_s   = $signed({2'b00, w_eff});
    h_s   = $signed({2'b00, h_eff});
    lo_x  = c_s - rad_s;
    hi_x  = c_s + rad_s;
    lo_y  = r_s - rad_s;
    hi_y  = r_s + rad_s;
    x0_s  = (lo_x < 9'sd0) ? 9'sd0 : lo_x;
    y0_s  = (lo_y < 9'sd0) ? 9'sd0 : lo_y;
    x1_s  = (hi_x > w_s - 9'sd1) ? w_s - 9'sd1 : hi_x;
    y1_s  = (hi_y > h_s - 9'sd1) ? h_s - 9'sd1 : hi_y;
  end

  // Shared add/compare unit: subtract for max and min, add for sum and mean.
  logic signed [SW-1:0] v_ext;
  logic                 alu_sub;
  logic signed [SW:0]   alu_b;
  logic signed [SW:0]   alu_out;
  logic                 acc_lt_v;
  logic                 cell_skip;

  always_comb begin
    v_ext     = SW'($signed(mem_rdata));
    alu_sub   = (op_mode == fws_pkg::OP_MAX) || (op_mode == fws_pkg::OP_MIN);
    alu_b     = alu_sub ? ~{v_ext[SW-1], v_ext} : {v_ext[SW-1], v_ext};
    alu_out   = {acc[SW-1], acc} + alu_b + (SW+1)'(alu_sub);
    acc_lt_v  = alu_out[SW];
    cell_skip = skip_enable && ($signed(mem_rdata) == missing_value);
  end

  assign div_start = (state == S_POST) && acc_valid && (op_mode == fws_pkg::OP_MEAN);

  fws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer, walk counters, accumulator and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      rd_pend   <= 1'b0;
      acc_valid <= 1'b0;
      count     <= '0;
    end else begin
      done    <= 1'b0;
      rd_pend <= (state == S_WALK);

      // Fold the cell read in the previous cycle.
      if (rd_pend && !cell_skip) begin
        count     <= count + 1'b1;
        acc_valid <= 1'b1;
        if (!acc_valid) begin
          acc <= v_ext;
        end else begin
          unique case (op_mode)
            fws_pkg::OP_MAX:  if (acc_lt_v) acc <= v_ext;
            fws_pkg::OP_MIN:  if (!acc_lt_v) acc <= v_ext;
            fws_pkg::OP_SUM,
            fws_pkg::OP_MEAN: acc <= alu_out[SW-1:0];
          endcase
        end
      end

      unique case (state)
        S_IDLE: begin
          if (item_take && (cmd == fws_pkg::CMD_QUERY)) begin
            col_q <= col;
            row_q <= row;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          x0        <= x0_s[XY_W-1:0];
          x1        <= x1_s[XY_W-1:0];
          y0        <= y0_s[XY_W-1:0];
          y1        <= y1_s[XY_W-1:0];
          win_empty <= (x0_s > x1_s) || (y0_s > y1_s);
          state     <= S_PREP;
        end
        S_PREP: begin
          acc_valid <= 1'b0;
          count     <= '0;
          x         <= x0;
          y         <= y0;
          rowbase   <= ADDR_W'(int'(y0) * MAX_COLS);
          state     <= win_empty ? S_POST : S_WALK;
        end
        S_WALK: begin
          if (x == x1) begin
            x       <= x0;
            y       <= y + 1'b1;
            rowbase <= rowbase + ADDR_W'(MAX_COLS);
            if (y == y1) begin
              state <= S_DRAIN;
            end
          end else begin
            x <= x + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_POST;
        end
        S_POST: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            done        <= 1'b1;
            stat_value  <= acc_valid ? acc : SW'(missing_value);
            valid_count <= count;
            empty_res   <= !acc_valid;
            state       <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            done        <= 1'b1;
            stat_value  <= div_quo;
            valid_count <= count;
            empty_res   <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A result only leaves the final or the divide state.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_POST || $past(state) == S_DIV))
    else $error("result shown outside the final states");

  // A query never ends without its result.
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("query ended without a result");

  // An empty window reports no valid cells.
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    (done && empty_res) |-> (valid_count == '0))
    else $error("empty result with nonzero count");

  // Read data is only folded while the walk or its drain runs.
  a_rd_window: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_WALK || state == S_DRAIN))
    else $error("memory read folded outside the walk");
`endif

endmodule

/* rtl/fws_ram.sv */
// ----------------------------------------------------------------------------
// fws_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fws_div.sv */
// ----------------------------------------------------------------------------
// fws_div: bit-serial signed by unsigned divider
// Restoring division of a signed dividend by an unsigned count, one quotient
// bit per cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module fws_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [fws_pkg::STAT_W-1:0]   dividend,
  input  logic        [fws_pkg::CNT_W-1:0]    divisor,
  output logic                                done,
  output logic signed [fws_pkg::STAT_W-1:0]   quotient
);

  localparam int SW = fws_pkg::STAT_W;
  localparam int CW = fws_pkg::CNT_W;
  localparam int STEP_W = $clog2(SW + 1);

  logic              active;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [SW-1:0]     quo;
  logic [CW-1:0]     rem;

  logic [CW:0] shifted;
  logic [CW:0] trial;
  logic        fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, quo[SW-1]};
    trial   = shifted - {1'b0, divisor};
    fits    = (shifted >= {1'b0, divisor});
  end

  // Step sequencer; the last cycle applies the sign.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= STEP_W'(SW);
        neg    <= dividend[SW-1];
        quo    <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
        rem    <= '0;
      end else if (active) begin
        if (step == '0) begin
          active   <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? -$signed(quo) : $signed(quo);
        end else begin
          step <= step - 1'b1;
          rem  <= fits ? trial[CW-1:0] : shifted[CW-1:0];
          quo  <= {quo[SW-2:0], fits};
        end
      end
    end
  end

endmodule

/* tb/sv/focal_window_stats_check.sv */
// ----------------------------------------------------------------------------
// focal_window_stats_check: result predictor for the focal window statistics
// Watches the item, result and configuration ports of the block, keeps its
// own copy of the grid and the registers, works out the statistic for every
// accepted query and compares it field by field with the result shown.
// ----------------------------------------------------------------------------
module focal_window_stats_check
  import fws_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cmd,
  input  logic        [POS_W-1:0]       col,
  input  logic        [POS_W-1:0]       row,
  input  logic signed [SAMPLE_W-1:0]    sample,
  input  logic                          done,
  input  logic signed [STAT_W-1:0]      stat_value,
  input  logic        [CNT_W-1:0]       valid_count,
  input  logic                          empty_res,
  input  logic                          cfg_we,
  input  logic        [CFG_IDX_W-1:0]   cfg_addr,
  input  logic        [CFG_DATA_W-1:0]  cfg_wdata,
  output int                            stats_in_flight,
  output int                            mismatches
);

  localparam int COLS      = MAX_COLS_DEF;
  localparam int ROWS      = MAX_ROWS_DEF;
  localparam int RAD_LIMIT = MAX_RADIUS_DEF;

  typedef struct packed {
    logic signed [STAT_W-1:0] stat;
    logic        [CNT_W-1:0]  count;
    logic                     empty;
  } window_stat_t;

  // Mirror of the grid and of the configuration registers.
  logic signed [SAMPLE_W-1:0] cells [COLS*ROWS];
  logic        [DIM_W-1:0]    grid_width_r;
  logic        [DIM_W-1:0]    grid_height_r;
  logic        [RAD_W-1:0]    radius_r;
  op_t                        op_r;
  logic                       skip_r;
  logic signed [SAMPLE_W-1:0] missing_r;

  // Statistics of queries taken whose results have not been shown yet.
  window_stat_t pending_stats[$];

  // Walk the clipped window around (cx, cy) and fold the valid cells.
  function automatic window_stat_t window_statistic(input int cx, input int cy);
    int w, h, rad, x0, x1, y0, y1, n;
    longint acc;
    bit seen;
    logic signed [SAMPLE_W-1:0] v;
    window_stat_t r;
    w = (grid_width_r < COLS) ? int'(grid_width_r) : COLS;
    h = (grid_height_r < ROWS) ? int'(grid_height_r) : ROWS;
    rad = (radius_r < RAD_LIMIT) ? int'(radius_r) : RAD_LIMIT;
    x0 = (cx - rad < 0) ? 0 : cx - rad;
    y0 = (cy - rad < 0) ? 0 : cy - rad;
    x1 = (cx + rad > w - 1) ? w - 1 : cx + rad;
    y1 = (cy + rad > h - 1) ? h - 1 : cy + rad;
    acc = 0;
    seen = 1'b0;
    n = 0;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        v = cells[y*COLS + x];
        if (!(skip_r && v == missing_r)) begin
          // The first valid cell loads the accumulator.
          if (!seen) begin
            acc = v;
            seen = 1'b1;
          end else begin
            case (op_r)
              OP_MAX: begin
                if (v > acc) acc = v;
              end
              OP_MIN: begin
                if (v < acc) acc = v;
              end
              default: begin
                acc += v;
              end
            endcase
          end
          n++;
        end
      end
    end
    // An empty window reports the missing value; the mean truncates.
    if (!seen) acc = longint'(missing_r);
    else if (op_r == OP_MEAN) acc = acc / n;
    r.stat = acc[STAT_W-1:0];
    r.count = n[CNT_W-1:0];
    r.empty = !seen;
    return r;
  endfunction

  always @(posedge clk) begin
    window_stat_t want;
    if (rst) begin
      grid_width_r = 7'd1;
      grid_height_r = 7'd1;
      radius_r = '0;
      op_r = OP_MAX;
      skip_r = 1'b0;
      missing_r = '0;
      pending_stats.delete();
    end else begin
      // Register writes; indexes past the list are ignored.
      if (cfg_we) begin
        case (cfg_addr)
          REG_GRID_WIDTH:    grid_width_r = cfg_wdata[DIM_W-1:0];
          REG_GRID_HEIGHT:   grid_height_r = cfg_wdata[DIM_W-1:0];
          REG_RADIUS:        radius_r = cfg_wdata[RAD_W-1:0];
          REG_OP_MODE:       op_r = op_t'(cfg_wdata[1:0]);
          REG_SKIP_ENABLE:   skip_r = cfg_wdata[0];
          REG_MISSING_VALUE: missing_r = cfg_wdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end

      // A shown result is matched against the oldest query.
      if (done) begin
        if (pending_stats.size() == 0) begin
          $error("result shown with no query waiting: stat_value %0d", stat_value);
          mismatches++;
        end else begin
          want = pending_stats.pop_front();
          if (want.stat !== stat_value) begin
            $error("stat_value: expected %0d, got %0d", want.stat, stat_value);
            mismatches++;
          end
          if (want.count !== valid_count) begin
            $error("valid_count: expected %0d, got %0d", want.count, valid_count);
            mismatches++;
          end
          if (want.empty !== empty_res) begin
            $error("empty_res: expected %0b, got %0b", want.empty, empty_res);
            mismatches++;
          end
        end
      end

      // An accepted item either updates the grid or queues a prediction.
      if (start && !busy) begin
        if (cmd == CMD_WRITE) cells[int'(row)*COLS + int'(col)] = sample;
        else pending_stats.push_back(window_statistic(int'(col), int'(row)));
      end
    end
    stats_in_flight <= pending_stats.size();
  end

endmodule

/* tb/sv/focal_window_stats_unit_test.sv */
// ----------------------------------------------------------------------------
// focal_window_stats_unit_test: testbench of the focal window statistics unit
// Fills the regions of the grid that the directed queries reach, runs a
// directed set of window queries over the edge cases, then random phases of
// writes and queries under varied settings, with random gaps between items.
// Random queries only aim at windows whose cells have all been written.
// A separate checker predicts every result.
// ----------------------------------------------------------------------------
module focal_window_stats_unit_test;
  import fws_pkg::*;

  localparam int LIMIT_CYCLES    = 5_000_000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int QUERY_TRIES     = 32;
  localparam int TAIL_CYCLES     = 300;
  localparam int SPAN            = 2 ** POS_W;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;

  // Register indexes past the end of the list; writes to them do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start;
  logic                         busy;
  logic                         cmd;
  logic        [POS_W-1:0]      col;
  logic        [POS_W-1:0]      row;
  logic signed [SAMPLE_W-1:0]   sample;
  logic                         done;
  logic signed [STAT_W-1:0]     stat_value;
  logic        [CNT_W-1:0]      valid_count;
  logic                         empty_res;
  logic                         cfg_we;
  logic        [CFG_IDX_W-1:0]  cfg_addr;
  logic        [CFG_DATA_W-1:0] cfg_wdata;

  int stats_in_flight;
  int mismatches;
  int cycle_count = 0;

  // Stimulus state: no-gap stretches and the settings currently in force.
  bit                         steady = 1'b0;
  logic signed [SAMPLE_W-1:0] missing_now = '0;
  int                         width_now = 1;
  int                         height_now = 1;
  int                         radius_now = 0;

  // Cells that have been written at least once.
  bit written [MAX_COLS_DEF*MAX_ROWS_DEF];

  always #2 clk = ~clk;

  focal_window_stats_unit dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cmd(cmd), .col(col), .row(row), .sample(sample),
    .done(done), .stat_value(stat_value), .valid_count(valid_count),
    .empty_res(empty_res),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  focal_window_stats_check watch (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cmd(cmd), .col(col), .row(row), .sample(sample),
    .done(done), .stat_value(stat_value), .valid_count(valid_count),
    .empty_res(empty_res),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .stats_in_flight(stats_in_flight), .mismatches(mismatches)
  );

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[focal_window_stats_unit] ERROR");
      $finish;
    end
  end

  // Sample values biased toward the extremes and the current missing marker.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2, 3: return missing_now;
      4: return int'($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_missing();
    case ($urandom_range(0, 4))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      3: return int'($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Grid sizes, including zero and values above the store size.
  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(MAX_COLS_DEF + 1, 2 ** DIM_W - 1);
      2: return MAX_COLS_DEF;
      3: return 1;
      default: return $urandom_range(1, MAX_COLS_DEF);
    endcase
  endfunction

  // Coordinates mostly inside the configured grid, sometimes anywhere.
  function automatic int pick_pos(input int dim);
    int reach;
    reach = (dim > SPAN) ? SPAN : dim;
    if (reach == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, SPAN - 1);
    return $urandom_range(0, reach - 1);
  endfunction

  // True when every cell of the clipped window around (cx, cy) was written.
  function automatic bit window_ready(input int cx, input int cy);
    int w, h, rad, x0, x1, y0, y1;
    w = (width_now < MAX_COLS_DEF) ? width_now : MAX_COLS_DEF;
    h = (height_now < MAX_ROWS_DEF) ? height_now : MAX_ROWS_DEF;
    rad = (radius_now < MAX_RADIUS_DEF) ? radius_now : MAX_RADIUS_DEF;
    x0 = (cx - rad < 0) ? 0 : cx - rad;
    y0 = (cy - rad < 0) ? 0 : cy - rad;
    x1 = (cx + rad > w - 1) ? w - 1 : cx + rad;
    y1 = (cy + rad > h - 1) ? h - 1 : cy + rad;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        if (!written[y*MAX_COLS_DEF + x]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Present one item after a random gap and hold it until it is taken.
  task automatic put_item(input logic c, input int x, input int y,
                          input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    col <= x[POS_W-1:0];
    row <= y[POS_W-1:0];
    sample <= s;
    do @(posedge clk); while (busy);
    if (c == CMD_WRITE) begin
      written[int'(y[POS_W-1:0])*MAX_COLS_DEF + int'(x[POS_W-1:0])] = 1'b1;
    end
  endtask

  // Stop sending and wait until every query has returned its result.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (stats_in_flight != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write every register once the block is idle, plus one unmapped index.
  task automatic set_window(input int w, input int h, input int r, input op_t op,
                            input logic skip, input logic signed [SAMPLE_W-1:0] miss);
    settle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_OP_MODE, CFG_DATA_W'(op));
    write_reg(REG_SKIP_ENABLE, CFG_DATA_W'(skip));
    write_reg(REG_MISSING_VALUE, miss);
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    cfg_we <= 1'b0;
    width_now = w;
    height_now = h;
    radius_now = r;
    missing_now = miss;
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] fill_val;
    op_t op_pick;
    int qx, qy, tries;
    start = 1'b0;
    cmd = CMD_WRITE;
    col = '0;
    row = '0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_GRID_WIDTH;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Fill the top left region and both bottom corners, which the directed
    // queries reach. The top left 15 x 15 block holds the most negative
    // sample and the block beside it the most positive one, for full-window
    // sums and means.
    for (int y = 0; y < MAX_ROWS_DEF; y++) begin
      for (int x = 0; x < MAX_COLS_DEF; x++) begin
        if ((y < 16 && x < 32) || (y >= 56 && (x < 8 || x >= 56))) begin
          if (y < 15 && x < 15) fill_val = SAMPLE_MIN;
          else if (y < 15 && x >= 16 && x < 31) fill_val = SAMPLE_MAX;
          else fill_val = pick_sample();
          put_item(CMD_WRITE, x, y, fill_val);
        end
      end
    end

    // Settings after reset: a one-cell grid, and a centre outside it.
    put_item(CMD_QUERY, 0, 0, $urandom);
    put_item(CMD_QUERY, 5, 5, $urandom);

    // Full windows of extreme samples: widest sums and exact means.
    set_window(64, 64, 7, OP_SUM, 1'b0, '0);
    put_item(CMD_QUERY, 7, 7, $urandom);
    put_item(CMD_QUERY, 23, 7, $urandom);
    set_window(64, 64, 7, OP_MEAN, 1'b0, '0);
    put_item(CMD_QUERY, 7, 7, $urandom);
    put_item(CMD_QUERY, 23, 7, $urandom);
    set_window(64, 64, 7, OP_MAX, 1'b0, '0);
    put_item(CMD_QUERY, 15, 7, $urandom);
    set_window(64, 64, 7, OP_MIN, 1'b0, '0);
    put_item(CMD_QUERY, 15, 7, $urandom);

    // Every cell skipped gives an empty window, for sum and for mean; then a partly skipped mean.
    set_window(64, 64, 7, OP_SUM, 1'b1, SAMPLE_MIN);
    put_item(CMD_QUERY, 7, 7, $urandom);
    set_window(64, 64, 7, OP_MEAN, 1'b1, SAMPLE_MIN);
    put_item(CMD_QUERY, 7, 7, $urandom);
    put_item(CMD_QUERY, 15, 7, $urandom);

    // A zero width empties every window.
    set_window(0, 64, 3, OP_MAX, 1'b0, SAMPLE_MAX);
    put_item(CMD_QUERY, 3, 3, $urandom);

    // Sizes above the store are cut down to it.
    set_window(127, 127, 7, OP_MAX, 1'b0, '0);
    put_item(CMD_QUERY, 63, 63, $urandom);
    put_item(CMD_QUERY, 0, 63, $urandom);

    // Small grid: a write outside it, centres outside and on its edge.
    set_window(10, 10, 7, OP_SUM, 1'b0, '0);
    put_item(CMD_WRITE, 50, 50, 123);
    put_item(CMD_QUERY, 40, 40, $urandom);
    put_item(CMD_QUERY, 12, 12, $urandom);
    put_item(CMD_QUERY, 9, 0, $urandom);
    put_item(CMD_WRITE, 63, 63, SAMPLE_MAX);

    // The cells written outside the small grid are read back once it grows.
    set_window(64, 64, 0, OP_MIN, 1'b0, '0);
    put_item(CMD_QUERY, 50, 50, $urandom);
    put_item(CMD_QUERY, 63, 63, $urandom);

    // Random phases, each under its own settings.
    for (int p = 0; p < PHASES; p++) begin
      op_pick = op_t'($urandom_range(0, 3));
      case (p)
        0: set_window(64, 64, 7, op_pick, 1'b1, pick_missing());
        1: set_window(1, 1, 0, op_pick, 1'b0, pick_missing());
        2: set_window(64, 64, 7, OP_MEAN, 1'b1, pick_missing());
        default: set_window(pick_dim(), pick_dim(), $urandom_range(0, 7), op_pick,
                            $urandom_range(0, 1) == 1, pick_missing());
      endcase
      steady = $urandom_range(0, 3) == 0;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 29) == 0) steady = !steady;
        if ($urandom_range(0, 39) == 0) settle();
        if ($urandom_range(0, 9) < 4) begin
          put_item(CMD_WRITE, pick_pos(width_now), pick_pos(height_now), pick_sample());
        end else begin
          // Look for a centre whose window holds only written cells.
          qx = pick_pos(width_now);
          qy = pick_pos(height_now);
          tries = 1;
          while (!window_ready(qx, qy) && tries < QUERY_TRIES) begin
            qx = pick_pos(width_now);
            qy = pick_pos(height_now);
            tries++;
          end
          if (window_ready(qx, qy)) put_item(CMD_QUERY, qx, qy, $urandom);
          else put_item(CMD_WRITE, qx, qy, pick_sample());
        end
      end
    end

    // Drain, then watch a while longer for stray results.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && stats_in_flight == 0) begin
      $display("[focal_window_stats_unit] OK");
    end else begin
      $display("[focal_window_stats_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/fws_pkg.sv
rtl/fws_ram.sv
rtl/fws_div.sv
rtl/focal_window_stats_unit.sv
tb/sv/focal_window_stats_check.sv
tb/sv/focal_window_stats_unit_test.sv
